// ----- src/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam int CpW   = 21;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;
  localparam logic [CpW-1:0] SuppBase = 21'h010000;
  localparam logic [15:0]    HiSurr   = 16'hD800;
  localparam logic [15:0]    LoSurr   = 16'hDC00;

  // One decoded code point waiting for the back end
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           fin;
    logic           pair;
  } qent_t;

endpackage

// ----- src/u8u16_front.sv -----
// Front end: accepts bytes, tracks the open sequence, emits code points.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      final_byte_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_output_utf32_i,
  output logic                      emit_o,
  output u8u16_pkg::qent_t          ent_o
);
  import u8u16_pkg::*;

  logic [CpW-1:0] pp_q, pp_d;
  logic [1:0]     due_q, due_d;
  logic           mode_q;
  logic           lead;
  logic [CpW-1:0] lead_pp;
  logic [1:0]     lead_due;
  logic [CpW-1:0] cont_pp;
  logic [1:0]     cont_due;
  logic [CpW-1:0] cp;

  always_comb begin
    lead     = 1'b0;
    lead_pp  = '0;
    lead_due = '0;
    if (data_byte_i[7:5] == 3'b110) begin
      lead     = 1'b1;
      lead_pp  = {16'b0, data_byte_i[4:0]};
      lead_due = 2'd1;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      lead     = 1'b1;
      lead_pp  = {17'b0, data_byte_i[3:0]};
      lead_due = 2'd2;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      lead     = 1'b1;
      lead_pp  = {18'b0, data_byte_i[2:0]};
      lead_due = 2'd3;
    end
  end

  assign cont_pp  = {pp_q[CpW-7:0], data_byte_i[5:0]};
  assign cont_due = due_q - 2'd1;

  always_comb begin
    emit_o = 1'b0;
    cp     = '0;
    pp_d   = pp_q;
    due_d  = due_q;
    if (accept_i) begin
      if (due_q == 2'd0) begin
        if (!data_byte_i[7]) begin
          emit_o = 1'b1;
          cp     = {13'b0, data_byte_i};
        end else if (lead) begin
          if (final_byte_i) begin
            emit_o = 1'b1;
            cp     = lead_pp;
            pp_d   = '0;
            due_d  = '0;
          end else begin
            pp_d  = lead_pp;
            due_d = lead_due;
          end
        end else begin
          emit_o = 1'b1;
          cp     = ReplChar;
        end
      end else begin
        if (cont_due != 2'd0 && !final_byte_i) begin
          pp_d  = cont_pp;
          due_d = cont_due;
        end else begin
          emit_o = 1'b1;
          cp     = cont_pp;
          pp_d   = '0;
          due_d  = '0;
        end
      end
    end
  end

  assign ent_o.cp   = cp;
  assign ent_o.fin  = final_byte_i;
  assign ent_o.pair = !mode_q && (|cp[CpW-1:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= '0;
      due_q  <= '0;
      mode_q <= 1'b0;
    end else begin
      pp_q  <= pp_d;
      due_q <= due_d;
      if (cfg_we_i) begin
        mode_q <= cfg_output_utf32_i;
      end
    end
  end

endmodule

// ----- src/u8u16_queue.sv -----
// Short register queue of decoded code points between front and back ends.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  u8u16_pkg::qent_t wr_ent_i,
  input  logic             rd_i,
  output u8u16_pkg::qent_t rd_ent_o,
  output logic             full_o,
  output logic             empty_o
);
  import u8u16_pkg::*;

  qent_t          ent_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o   = (cnt_q == QDepth[QPtrW:0]);
  assign empty_o  = (cnt_q == '0);
  assign rd_ent_o = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ent_q[wr_ptr_q] <= wr_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- src/u8u16_back.sv -----
// Back end: splits code points into units and holds the output register.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  u8u16_pkg::qent_t          ent_i,
  input  logic                      q_empty_i,
  output logic                      q_pop_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [u8u16_pkg::CpW-1:0] code_unit_o,
  output logic                      run_last_o,
  output logic                      text_end_o
);
  import u8u16_pkg::*;

  logic           out_vld_q;
  logic           half_q;
  logic           load;
  logic [CpW-1:0] adj;
  logic [15:0]    hi_unit;
  logic [15:0]    lo_unit;
  logic [CpW-1:0] unit_d;
  logic           last_d;
  logic           end_d;
  logic [CpW-1:0] unit_q;
  logic           last_q;
  logic           end_q;

  assign load    = (!out_vld_q || pop_i) && !q_empty_i;
  assign adj     = ent_i.cp - SuppBase;
  assign hi_unit = HiSurr + {5'b0, adj[CpW-1:10]};
  assign lo_unit = LoSurr | {6'b0, adj[9:0]};

  always_comb begin
    q_pop_o = 1'b0;
    unit_d  = ent_i.cp;
    last_d  = 1'b1;
    end_d   = ent_i.fin;
    if (ent_i.pair && !half_q) begin
      unit_d = {5'b0, hi_unit};
      last_d = 1'b0;
      end_d  = 1'b0;
    end else begin
      q_pop_o = load;
      if (ent_i.pair) begin
        unit_d = {5'b0, lo_unit};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q <= unit_d;
      last_q <= last_d;
      end_q  <= end_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      half_q    <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        half_q    <= ent_i.pair && !half_q;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign empty_o     = !out_vld_q;
  assign code_unit_o = unit_q;
  assign run_last_o  = last_q;
  assign text_end_o  = end_q;

endmodule

// ----- src/utf8_to_utf16_transcoder_core.sv -----
// UTF-8 to UTF-16/UTF-32 transcoder, top level. Uses u8u16_front, u8u16_queue,
// u8u16_back and u8u16_pkg.
// A byte that completes a code point is written into the queue, and its first unit then loads into the output register.
// Throughput: one byte per cycle while the queue is not full; a surrogate pair leaves the output register as two units.
// A four-entry queue decouples the byte decoder from the unit splitter.
// Reset clears the open sequence, the queue and the output stage; mode resets to UTF-16.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                data_byte_i,
  input  logic                      final_byte_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [u8u16_pkg::CpW-1:0] code_unit_o,
  output logic                      run_last_o,
  output logic                      text_end_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_output_utf32_i
);
  import u8u16_pkg::*;

  logic  accept;
  logic  emit;
  qent_t wr_ent;
  qent_t rd_ent;
  logic  q_empty;
  logic  q_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  u8u16_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .data_byte_i        (data_byte_i),
    .final_byte_i       (final_byte_i),
    .cfg_we_i           (cfg_valid_i),
    .cfg_output_utf32_i (cfg_output_utf32_i),
    .emit_o             (emit),
    .ent_o              (wr_ent)
  );

  u8u16_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (emit),
    .wr_ent_i (wr_ent),
    .rd_i     (q_pop),
    .rd_ent_o (rd_ent),
    .full_o   (full),
    .empty_o  (q_empty)
  );

  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_i       (rd_ent),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .code_unit_o (code_unit_o),
    .run_last_o  (run_last_o),
    .text_end_o  (text_end_o)
  );

endmodule

// ----- tb/sv/tb_utf8_to_utf16_transcoder_core.sv -----
// Testbench for utf8_to_utf16_transcoder_core: UTF-8 bytes in, UTF-16 units or raw code
// points out, checked against a byte-level decoder kept in step with every accepted item.
// Depends on u8u16_pkg and the transcoder RTL only.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder_core;
  import u8u16_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int MaxPrinted = 40;

  localparam logic [2:0]     Lead2    = 3'b110;
  localparam logic [3:0]     Lead3    = 4'b1110;
  localparam logic [4:0]     Lead4    = 5'b11110;
  localparam logic [1:0]     ContTag  = 2'b10;
  localparam logic [CpW-1:0] BmpTop   = 21'h00FFFF;
  localparam logic [CpW-1:0] SurrMask = 21'h0003FF;

  typedef struct packed {
    logic [CpW-1:0] unit;
    logic           run_last;
    logic           text_end;
  } unit_t;

  logic           clk;
  logic           rst_n;
  logic           push;
  logic           full;
  logic [7:0]     data_byte;
  logic           final_byte;
  logic           empty;
  logic           pop = 1'b0;
  logic [CpW-1:0] code_unit;
  logic           run_last;
  logic           text_end;
  logic           cfg_valid;
  logic           cfg_ready;
  logic           cfg_utf32;

  // decoder state and mode as the block should hold them
  logic [CpW-1:0] seq_point;
  logic [1:0]     seq_due;
  logic           mode_utf32;

  unit_t unit_q[$];
  int    err_cnt   = 0;
  int    bytes_in  = 0;
  int    units_out = 0;
  int    pairs_out = 0;
  int    cycles    = 0;
  bit    tx_gaps   = 1'b1;
  bit    rx_gaps   = 1'b1;
  bit    hold_tog  = 1'b0;
  bit    hold_seen = 1'b0;
  int    hold_left = 0;
  int    gap_left  = 0;

  utf8_to_utf16_transcoder_core dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .push               (push),
    .full               (full),
    .data_byte_i        (data_byte),
    .final_byte_i       (final_byte),
    .empty              (empty),
    .pop                (pop),
    .code_unit_o        (code_unit),
    .run_last_o         (run_last),
    .text_end_o         (text_end),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_output_utf32_i (cfg_utf32)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d units still due", cycles, unit_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold when hold_tog flips
  always @(negedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HoldCycles;
      pop       <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      pop      <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      gap_left <= $urandom_range(0, 14);
      pop      <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic report(input string what, input logic [CpW-1:0] got,
                        input logic [CpW-1:0] want);
    if (err_cnt < MaxPrinted)
      $display("MISMATCH %s: got %h expected %h (unit %0d)", what, got, want, units_out);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    unit_t want;
    if (rst_n && pop && !empty) begin
      if (unit_q.size() == 0) begin
        report("unexpected unit", code_unit, '0);
      end else begin
        want = unit_q.pop_front();
        if (code_unit !== want.unit) report("code_unit", code_unit, want.unit);
        if (run_last !== want.run_last) report("run_last", run_last, want.run_last);
        if (text_end !== want.text_end) report("text_end", text_end, want.text_end);
      end
      units_out++;
    end
  end

  function automatic void add_unit(input logic [CpW-1:0] u, input bit last, input bit fin);
    unit_t ent;
    ent.unit     = u;
    ent.run_last = last;
    ent.text_end = fin;
    unit_q.insert(unit_q.size(), ent);
  endfunction

  function automatic void emit_point(input logic [CpW-1:0] cp, input bit fin);
    logic [CpW-1:0] adj;
    if (mode_utf32 || cp <= BmpTop) begin
      add_unit(cp, 1'b1, fin);
    end else begin
      adj = cp - SuppBase;
      add_unit(CpW'(HiSurr) + (adj >> 10), 1'b0, 1'b0);
      add_unit(CpW'(LoSurr) + (adj & SurrMask), 1'b1, fin);
      pairs_out++;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input bit fin);
    logic [CpW-1:0] cp;
    if (seq_due == 2'd0) begin
      if (!b[7]) begin
        emit_point(CpW'(b), fin);
        return;
      end
      if (b[7:5] == Lead2) begin
        seq_point = CpW'(b[4:0]);
        seq_due   = 2'd1;
      end else if (b[7:4] == Lead3) begin
        seq_point = CpW'(b[3:0]);
        seq_due   = 2'd2;
      end else if (b[7:3] == Lead4) begin
        seq_point = CpW'(b[2:0]);
        seq_due   = 2'd3;
      end else begin
        emit_point(ReplChar, fin);
        return;
      end
      if (!fin) return;
    end else begin
      seq_point = {seq_point[CpW-7:0], b[5:0]};
      seq_due   = seq_due - 2'd1;
      if (seq_due != 2'd0 && !fin) return;
    end
    cp        = seq_point;
    seq_point = '0;
    seq_due   = 2'd0;
    emit_point(cp, fin);
  endfunction

  // all stimulus tasks start and end at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit fin);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    push       <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (full);
    decode_byte(b, fin);
    bytes_in++;
    @(negedge clk);
  endtask

  task automatic drain;
    push <= 1'b0;
    while (unit_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_mode(input bit m);
    cfg_valid <= 1'b1;
    cfg_utf32 <= m;
    do @(posedge clk); while (!cfg_ready);
    mode_utf32 = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_utf32 <= 1'($urandom_range(0, 1));
  endtask

  task automatic set_idling(input bit tx, input bit rx);
    @(posedge clk);
    tx_gaps = tx;
    rx_gaps = rx;
    @(negedge clk);
  endtask

  // one character, mostly well formed; some noise, bad continuations and cut-offs
  task automatic send_symbol;
    logic [7:0] seq [4];
    int         len;
    int         cut;
    bit         fin_end;
    if ($urandom_range(0, 99) < 15) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    len = $urandom_range(1, 4);
    case (len)
      1: seq[0] = 8'($urandom_range(0, 127));
      2: seq[0] = {Lead2, 5'($urandom_range(0, 31))};
      3: seq[0] = {Lead3, 4'($urandom_range(0, 15))};
      default: seq[0] = {Lead4, 3'($urandom_range(0, 7))};
    endcase
    for (int i = 1; i < len; i++) begin
      seq[i] = {ContTag, 6'($urandom_range(0, 63))};
      if ($urandom_range(0, 15) == 0) seq[i] = 8'($urandom_range(0, 255));
    end
    cut = len;
    if (len > 1 && $urandom_range(0, 11) == 0) cut = $urandom_range(1, len - 1);
    fin_end = (cut < len) || ($urandom_range(0, 9) == 0);
    for (int i = 0; i < cut; i++) send_byte(seq[i], fin_end && (i == cut - 1));
  endtask

  task automatic send_random(input int n);
    int stop_at;
    stop_at = bytes_in + n;
    while (bytes_in < stop_at) send_symbol();
  endtask

  task automatic test_directed_utf16;
    write_mode(1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b0);  // stray continuation
    send_byte(8'hFF, 1'b1);  // stray, not a lead
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF7, 1'b0);  // above U+10FFFF, still split into a pair
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);  // continuation taken unchecked
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);  // sequence cut off by end of string
    send_byte(8'hF0, 1'b1);  // lead byte is itself the last
    drain();
  endtask

  task automatic test_mode_mid_sequence;
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    drain();
    write_mode(1'b1);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    drain();
    write_mode(1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    drain();
  endtask

  task automatic test_random_modes;
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      send_random(220);
      drain();
    end
  endtask

  task automatic test_backpressure;
    set_idling(1'b0, 1'b1);
    @(posedge clk);
    hold_tog = ~hold_tog;
    @(negedge clk);
    send_random(80);
    drain();
  endtask

  task automatic test_full_rate;
    write_mode(1'b1);
    set_idling(1'b0, 1'b0);
    send_random(100);
    drain();
    write_mode(1'b0);
    send_random(100);
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    push       = 1'b0;
    data_byte  = 8'h00;
    final_byte = 1'b0;
    cfg_valid  = 1'b0;
    cfg_utf32  = 1'b0;
    seq_point  = '0;
    seq_due    = 2'd0;
    mode_utf32 = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_utf16();
    test_mode_mid_sequence();
    test_random_modes();
    test_backpressure();
    test_full_rate();

    $display("Covered %0d bytes and %0d units (%0d surrogate pairs) in both output modes,",
             bytes_in, units_out, pairs_out);
    $display("with stray, cut-off and oversized sequences, stalls and a full queue.");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
